FILE: rtl/u8d_pkg.sv
package u8d_pkg;

  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] CONT_BITS  = 8'h3F;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_CONT,
    CLS_BAD
  } u8d_class_e;

  typedef struct packed {
    u8d_class_e  cls;
    logic [7:0]  data;
  } u8d_entry_t;

endpackage

FILE: rtl/u8d_if.sv
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_cp_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_point;
  logic        end_of_string;
  logic        bad_sequence;

  modport source (output valid, output code_point, output end_of_string,
                  output bad_sequence, input ready);
  modport sink   (input valid, input code_point, input end_of_string,
                  input bad_sequence, output ready);
endinterface

FILE: rtl/u8d_front.sv
module u8d_front
  import u8d_pkg::*;
(
  u8d_byte_if.sink   in_i,
  input  logic       full_i,
  output logic       push_o,
  output u8d_entry_t entry_o
);

  logic [7:0] b;

  assign b            = in_i.in_byte;
  assign in_i.ready   = !full_i;
  assign push_o       = in_i.valid && !full_i;

  always_comb begin
    entry_o.data = b;
    priority if (b == 8'h00) begin
      entry_o.cls = CLS_ZERO;
    end else if ((b & ASCII_MASK) == 8'h00) begin
      entry_o.cls = CLS_ASCII;
    end else if ((b & CONT_MASK) == CONT_TAG) begin
      entry_o.cls = CLS_CONT;
    end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
      entry_o.cls = CLS_LEAD2;
    end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
      entry_o.cls = CLS_LEAD3;
    end else begin
      entry_o.cls = CLS_BAD;
    end
  end

endmodule

FILE: rtl/u8d_fifo.sv
module u8d_fifo
  import u8d_pkg::*;
#(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  u8d_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output u8d_entry_t entry_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  u8d_entry_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count out of range");
`endif

endmodule

FILE: rtl/u8d_back.sv
module u8d_back
  import u8d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  u8d_entry_t entry_i,
  output logic       pop_o,
  u8d_cp_if.source   out_o
);

  logic [1:0]  rem_q, rem_d;
  logic [15:0] part_q, part_d;
  logic        disc_q, disc_d;
  logic        vld_q, vld_d;
  logic [15:0] cp_q;
  logic        eos_q;
  logic        bad_q;

  logic        emit;
  logic [15:0] res_cp;
  logic        res_eos;
  logic        res_bad;
  logic [7:0]  b;

  assign b     = entry_i.data;
  assign pop_o = !empty_i && (!vld_q || out_o.ready);

  always_comb begin
    rem_d   = rem_q;
    part_d  = part_q;
    disc_d  = disc_q;
    emit    = 1'b0;
    res_cp  = '0;
    res_eos = 1'b0;
    res_bad = 1'b0;
    if (pop_o) begin
      if (disc_q) begin
        if (entry_i.cls == CLS_ZERO) begin
          disc_d = 1'b0;
        end
      end else if (rem_q == 2'd0) begin
        unique case (entry_i.cls)
          CLS_ZERO: begin
            emit    = 1'b1;
            res_eos = 1'b1;
          end
          CLS_ASCII: begin
            emit   = 1'b1;
            res_cp = 16'(b);
          end
          CLS_LEAD2: begin
            part_d = 16'(b & LEAD2_BITS) << 6;
            rem_d  = 2'd1;
          end
          CLS_LEAD3: begin
            part_d = 16'(b & LEAD3_BITS) << 12;
            rem_d  = 2'd2;
          end
          default: begin
            disc_d  = 1'b1;
            emit    = 1'b1;
            res_eos = 1'b1;
            res_bad = 1'b1;
          end
        endcase
      end else begin
        priority if (entry_i.cls == CLS_ZERO) begin
          rem_d   = 2'd0;
          part_d  = '0;
          emit    = 1'b1;
          res_eos = 1'b1;
          res_bad = 1'b1;
        end else if (entry_i.cls != CLS_CONT) begin
          rem_d   = 2'd0;
          part_d  = '0;
          disc_d  = 1'b1;
          emit    = 1'b1;
          res_eos = 1'b1;
          res_bad = 1'b1;
        end else if (rem_q >= 2'd2) begin
          part_d = part_q | (16'(b & CONT_BITS) << 6);
          rem_d  = 2'd1;
        end else begin
          emit   = 1'b1;
          res_cp = part_q | 16'(b & CONT_BITS);
          rem_d  = 2'd0;
          part_d = '0;
        end
      end
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (pop_o && emit) begin
      vld_d = 1'b1;
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      part_q <= '0;
      disc_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      part_q <= part_d;
      disc_q <= disc_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      cp_q  <= res_cp;
      eos_q <= res_eos;
      bad_q <= res_bad;
    end
  end

  assign out_o.valid         = vld_q;
  assign out_o.code_point    = cp_q;
  assign out_o.end_of_string = eos_q;
  assign out_o.bad_sequence  = bad_q;

`ifndef SYNTH
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != 2'd3) else $error("remaining count reached three");

  a_disc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> (rem_q == 2'd0)) else $error("discarding inside a sequence");

  a_bad_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && bad_q) |-> (eos_q && cp_q == '0)) else $error("error beat malformed");
`endif

endmodule

FILE: rtl/utf8_to_codepoint_decoder_top.sv
// channel | dir | payload                                   | handshake
// in_i    | in  | in_byte[7:0]                              | valid/ready
// out_o   | out | code_point[15:0], end_of_string, bad_sequence | valid/ready
//
// One byte per cycle sustained while out_o is ready; a result's last byte
// passes the queue, then the output register. The rate is set by the decode
// step in the back end. Reset clears the decode state, the queue pointers and
// count and out_o.valid; no sweep. A two-entry queue plus the output register
// absorb output stalls; in_i.ready drops only when the queue is full.
module utf8_to_codepoint_decoder_top
  import u8d_pkg::*;
#(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  u8d_byte_if.sink in_i,
  u8d_cp_if.source out_o
);

  logic       push;
  logic       full;
  logic       pop;
  logic       empty;
  u8d_entry_t wr_entry;
  u8d_entry_t rd_entry;

  u8d_front u_front (
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (wr_entry)
  );

  u8d_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (wr_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (rd_entry)
  );

  u8d_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .entry_i (rd_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
